>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FRLW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition on one edge implies a consequence on the next.
`define FRLW_ASSERT_NEXT(lbl, ante, cons, msg) \
  `FRLW_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/frlw_pkg.sv
// ---------------------------------------------------------------------------
// frlw_pkg
// Shared constants, entry layout and controller/datapath interface types.
// ---------------------------------------------------------------------------
package frlw_pkg;

  localparam int unsigned FRLW_DEPTH = 16;
  localparam int unsigned ID_W       = 10;
  localparam int unsigned WAIT_W     = 16;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [WAIT_W-1:0] wt;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic set_status;
    logic ins_write;
    logic scan_start;
    logic scan_issue;
    logic copy_start;
    logic copy_issue;
    logic res_load;
  } frlw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic scan_last;
    logic copy_none;
    logic copy_last;
    logic out_free;
  } frlw_stat_t;

endpackage

>>> hw/rtl/frlw_ctrl.sv
// ---------------------------------------------------------------------------
// frlw_ctrl
// Sequencer for insert, scan and rotate passes over the entry store.
// ---------------------------------------------------------------------------
module frlw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  frlw_pkg::frlw_stat_t stat_i,
  output frlw_pkg::frlw_cmd_t  cmd_o
);
  import frlw_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_DISPATCH   = 8'b0000_0010,
    S_SCAN       = 8'b0000_0100,
    S_SCAN_WAIT  = 8'b0000_1000,
    S_COPY_START = 8'b0001_0000,
    S_COPY       = 8'b0010_0000,
    S_COPY_WAIT  = 8'b0100_0000,
    S_RESULT     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.set_status = 1'b1;
        state_d          = S_RESULT;
        if (stat_i.is_remove) begin
          if (!stat_i.empty) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end else if (!stat_i.full) begin
          cmd_o.ins_write = 1'b1;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        state_d = S_COPY_START;
      end
      S_COPY_START: begin
        cmd_o.copy_start = 1'b1;
        state_d          = stat_i.copy_none ? S_RESULT : S_COPY;
      end
      S_COPY: begin
        cmd_o.copy_issue = 1'b1;
        if (stat_i.copy_last) begin
          state_d = S_COPY_WAIT;
        end
      end
      S_COPY_WAIT: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/frlw_dp.sv
// ---------------------------------------------------------------------------
// frlw_dp
// Entry ring memory, ring pointers, maximum search and result register.
// ---------------------------------------------------------------------------
module frlw_dp #(
  parameter int unsigned DEPTH = frlw_pkg::FRLW_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  frlw_pkg::frlw_cmd_t                   cmd_i,
  output frlw_pkg::frlw_stat_t                  stat_o,
  input  logic                                  func_i,
  input  logic [frlw_pkg::ID_W-1:0]             proc_id_i,
  input  logic signed [frlw_pkg::WAIT_W-1:0]    wait_time_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic [frlw_pkg::STATUS_W-1:0]         status_o,
  output logic [frlw_pkg::ID_W-1:0]             removed_id_o,
  output logic signed [frlw_pkg::WAIT_W-1:0]    removed_wait_o
);
  import frlw_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW:0]   WRAP_SUM = (CW + 1)'(DEPTH);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
    return (pos == LAST_POS) ? '0 : pos + 1'b1;
  endfunction

  entry_t mem [DEPTH];

  logic                    func_q;
  entry_t                  item_q;
  logic [AW-1:0]           head_q;
  logic [CW-1:0]           count_q;
  logic [STATUS_W-1:0]     st_q;
  logic [AW-1:0]           ptr_q;
  logic [AW-1:0]           idx_q;
  logic [AW-1:0]           dst_q;
  entry_t                  rd_q;
  logic                    sc_rd_q;
  logic                    sc_first_q;
  logic [AW-1:0]           sc_off_q;
  logic [AW-1:0]           sc_pos_q;
  logic                    cp_rd_q;
  entry_t                  best_q;
  logic [AW-1:0]           best_off_q;
  logic [AW-1:0]           best_pos_q;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  entry_t                  out_entry_q;

  logic [CW:0]             tail_sum;
  logic [AW-1:0]           tail;
  logic                    full;
  logic                    empty;
  logic                    removing;
  logic                    rd_en;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  entry_t                  wr_data;

  // Tail of the ring: head plus fill count, wrapped once.
  assign tail_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
  assign tail     = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : AW'(tail_sum);

  assign full     = (count_q == FULL_CNT);
  assign empty    = (count_q == '0);
  assign removing = func_q && (st_q == STATUS_DONE);

  assign rd_en   = cmd_i.scan_issue || cmd_i.copy_issue;
  assign wr_en   = cmd_i.ins_write || cp_rd_q;
  assign wr_addr = cp_rd_q ? dst_q : tail;
  assign wr_data = cp_rd_q ? rd_q : item_q;

  always_comb begin
    stat_o.is_remove = func_q;
    stat_o.full      = full;
    stat_o.empty     = empty;
    stat_o.scan_last = (CW'(idx_q) == count_q - 1'b1);
    stat_o.copy_none = (best_off_q == '0);
    stat_o.copy_last = (idx_q == best_off_q - 1'b1);
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Entry store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[ptr_q];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      sc_rd_q     <= 1'b0;
      cp_rd_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sc_rd_q <= cmd_i.scan_issue;
      cp_rd_q <= cmd_i.copy_issue;
      if (cmd_i.ins_write) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.res_load && removing) begin
        head_q  <= ring_next(best_pos_q);
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q    <= func_i;
      item_q.id <= proc_id_i;
      item_q.wt <= wait_time_i;
    end
    if (cmd_i.set_status) begin
      if (func_q) begin
        st_q <= empty ? STATUS_EMPTY : STATUS_DONE;
      end else begin
        st_q <= full ? STATUS_FULL : STATUS_DONE;
      end
    end
    if (cmd_i.scan_start || cmd_i.copy_start) begin
      ptr_q <= head_q;
      idx_q <= '0;
    end else if (rd_en) begin
      ptr_q <= ring_next(ptr_q);
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.copy_start) begin
      dst_q <= tail;
    end else if (cp_rd_q) begin
      dst_q <= ring_next(dst_q);
    end
    sc_off_q   <= idx_q;
    sc_pos_q   <= ptr_q;
    sc_first_q <= (idx_q == '0);
    // Keep the first occurrence of the greatest wait.
    if (sc_rd_q && (sc_first_q || (rd_q.wt > best_q.wt))) begin
      best_q     <= rd_q;
      best_off_q <= sc_off_q;
      best_pos_q <= sc_pos_q;
    end
    if (cmd_i.res_load) begin
      out_status_q <= st_q;
      out_entry_q  <= removing ? best_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign removed_id_o   = out_entry_q.id;
  assign removed_wait_o = out_entry_q.wt;

endmodule

>>> hw/rtl/fifo_remove_longest_wait.sv
// ---------------------------------------------------------------------------
// fifo_remove_longest_wait
// Ring queue of process entries with insert and remove-longest-wait.
//
// Holds up to DEPTH entries (id, signed wait time) in a single-port-read
// memory ring. An insert appends at the tail. A remove with n entries held
// whose longest wait first appears k places behind the head scans all n
// entries for the maximum with one memory read per cycle, then moves the k
// entries ahead of it from head to tail with one read per cycle. The
// single read port of the entry memory sets both passes. One item is worked
// at a time; a new item is taken while the previous result still waits in
// the output register. Full and empty report through status with zero
// removed fields. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module fifo_remove_longest_wait #(
  parameter int unsigned DEPTH = frlw_pkg::FRLW_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  func_i,
  input  logic [frlw_pkg::ID_W-1:0]             proc_id_i,
  input  logic signed [frlw_pkg::WAIT_W-1:0]    wait_time_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [frlw_pkg::STATUS_W-1:0]         status_o,
  output logic [frlw_pkg::ID_W-1:0]             removed_id_o,
  output logic signed [frlw_pkg::WAIT_W-1:0]    removed_wait_o
);
  import frlw_pkg::*;

  // Command and status between sequencer and datapath.
  frlw_cmd_t  cmd;
  frlw_stat_t stat;

  // Sequencer: accepts a transfer only when idle, then steps the passes.
  frlw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: entry memory, ring pointers, max search, output register.
  frlw_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .proc_id_i      (proc_id_i),
    .wait_time_i    (wait_time_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .removed_id_o   (removed_id_o),
    .removed_wait_o (removed_wait_o)
  );

endmodule

>>> hw/rtl/frlw_checker.sv
// ---------------------------------------------------------------------------
// frlw_checker
// Port-level checks for the queue block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frlw_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [frlw_pkg::STATUS_W-1:0]      status_o,
  input logic [frlw_pkg::ID_W-1:0]          removed_id_o,
  input logic signed [frlw_pkg::WAIT_W-1:0] removed_wait_o
);
  import frlw_pkg::*;

  // Hold a stalled result.
  `FRLW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `FRLW_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(status_o) && $stable(removed_id_o) && $stable(removed_wait_o), "stalled result changed")
  // One item at a time: a transfer closes the input until its work is done.
  `FRLW_ASSERT_NEXT(a_in_busy, in_valid_i && !in_stall_o, in_stall_o, "input open right after transfer")
  // Full and empty results carry no removed entry.
  `FRLW_ASSERT(a_zero_fields, out_valid_o && (status_o != STATUS_DONE) |-> (removed_id_o == '0) && (removed_wait_o == '0), "nonzero fields on full or empty")

endmodule

bind fifo_remove_longest_wait frlw_checker u_frlw_checker (.*);

>>> tb/sv/frlw_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frlw_tb_pkg
// Request codes shared by the stimulus and the checker of the queue bench.
// ---------------------------------------------------------------------------
package frlw_tb_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

endpackage

>>> tb/sv/frlw_queue_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frlw_queue_checker
// Watches both channels of the queue, keeps its own copy of the ring and
// compares every result transfer with the outcome it predicts.
// ---------------------------------------------------------------------------
module frlw_queue_checker
  import frlw_pkg::*;
  import frlw_tb_pkg::*;
#(
  parameter int unsigned DEPTH = FRLW_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      func_i,
  input  logic [ID_W-1:0]           proc_id_i,
  input  logic signed [WAIT_W-1:0]  wait_time_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [STATUS_W-1:0]       status_i,
  input  logic [ID_W-1:0]           removed_id_i,
  input  logic signed [WAIT_W-1:0]  removed_wait_i,
  output int unsigned               owed_o,
  output int unsigned               errors_o
);

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [ID_W-1:0]          id;
    logic signed [WAIT_W-1:0] wt;
  } outcome_t;

  entry_t      ring_q [DEPTH];
  int unsigned head_pos;
  int unsigned fill;
  outcome_t    outcomes_due [$];
  outcome_t    due;

  initial begin
    head_pos = 0;
    fill     = 0;
    owed_o   = 0;
    errors_o = 0;
  end

  function automatic int unsigned wrap(int unsigned pos);
    return (pos >= DEPTH) ? pos - DEPTH : pos;
  endfunction

  // Apply one request to the ring copy and return the outcome it yields.
  function automatic outcome_t serve_request(logic op, logic [ID_W-1:0] id,
                                             logic signed [WAIT_W-1:0] wt);
    outcome_t                 res;
    int unsigned              pos;
    int unsigned              best_off;
    logic signed [WAIT_W-1:0] best;
    res        = '0;
    res.status = STATUS_DONE;
    if (op == FUNC_INSERT) begin
      if (fill >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        pos            = wrap(head_pos + fill);
        ring_q[pos].id = id;
        ring_q[pos].wt = wt;
        fill++;
      end
    end else if (fill == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      // first occurrence of the longest wait, counted from the head
      best_off = 0;
      best     = ring_q[head_pos].wt;
      for (int unsigned i = 1; i < fill; i++) begin
        pos = wrap(head_pos + i);
        if ($signed(ring_q[pos].wt) > best) begin
          best     = ring_q[pos].wt;
          best_off = i;
        end
      end
      // entries ahead of it go round to the tail in order
      for (int unsigned i = 0; i < best_off; i++) begin
        ring_q[wrap(head_pos + fill)] = ring_q[head_pos];
        head_pos = wrap(head_pos + 1);
      end
      res.id   = ring_q[head_pos].id;
      res.wt   = ring_q[head_pos].wt;
      head_pos = wrap(head_pos + 1);
      fill--;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] queue check: %s", $time, what);
    errors_o++;
  endtask

  // Take the result side first so a result never matches the request of
  // the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          due = outcomes_due.pop_front();
          if (status_i !== due.status)
            report_mismatch($sformatf("status %0d, predicted %0d", status_i, due.status));
          if (removed_id_i !== due.id)
            report_mismatch($sformatf("removed id %0d, predicted %0d",
                                      removed_id_i, due.id));
          if (removed_wait_i !== due.wt)
            report_mismatch($sformatf("removed wait %0d, predicted %0d",
                                      removed_wait_i, due.wt));
        end
      end
      if (in_valid_i && !in_stall_i)
        outcomes_due.push_back(serve_request(func_i, proc_id_i, wait_time_i));
      owed_o = outcomes_due.size();
    end
  end

endmodule

>>> tb/sv/tb_fifo_remove_longest_wait.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_fifo_remove_longest_wait
// Drives insert and remove requests into the longest-wait queue with random
// idling on both channels and two long output hold-offs; the checker beside
// the block predicts every result and counts mismatches for the verdict.
// ---------------------------------------------------------------------------
module tb_fifo_remove_longest_wait;
  import frlw_pkg::*;
  import frlw_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CALM_ITEMS   = 150;   // tail of the run without idling
  localparam int unsigned HOLD_CYCLES  = 400;   // long output hold-off
  localparam int unsigned DRAIN_CYCLES = 60;    // beyond the slowest remove

  // Waits of the directed fill: extremes, zero, minus one and several ties.
  localparam logic signed [WAIT_W-1:0] FILL_WAITS [16] = '{
    16'sh7FFF, 16'sh8000, 16'sd0,     -16'sd1,
    16'sh7FFF, 16'sd5,    16'sd5,     16'sh8000,
    16'sd7,    16'sd100,  -16'sd100,  16'sd7,
    16'sh7FFE, 16'sd1,    -16'sd2,    16'sd0
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     func_i;
  logic [ID_W-1:0]          proc_id_i;
  logic signed [WAIT_W-1:0] wait_time_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [STATUS_W-1:0]      status_o;
  logic [ID_W-1:0]          removed_id_o;
  logic signed [WAIT_W-1:0] removed_wait_o;

  int unsigned owed;
  int unsigned errors;

  // Stimulus controls shared with the receiver process.
  logic gaps_on;    // allow sender gaps in the current segment
  logic calm;       // last part of the run: no idling on either side
  logic hold_req;   // ask the receiver for one long hold-off

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  fifo_remove_longest_wait i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .proc_id_i      (proc_id_i),
    .wait_time_i    (wait_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .removed_id_o   (removed_id_o),
    .removed_wait_o (removed_wait_o)
  );

  frlw_queue_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .func_i         (func_i),
    .proc_id_i      (proc_id_i),
    .wait_time_i    (wait_time_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .removed_id_i   (removed_id_o),
    .removed_wait_i (removed_wait_o),
    .owed_o         (owed),
    .errors_o       (errors)
  );

  // Offer one request and hold it until its transfer. Enter and leave at a
  // falling edge; a gap, if any, drops valid before the request goes out.
  task automatic offer(input logic op, input logic [ID_W-1:0] id,
                       input logic signed [WAIT_W-1:0] wt);
    if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    func_i      = op;
    proc_id_i   = id;
    wait_time_i = wt;
    // hold the payload until an edge sees valid with no stall
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Mostly uniform waits, with bursts of a narrow band to force ties and
  // the odd extreme value.
  function automatic logic signed [WAIT_W-1:0] pick_wait();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      1: return ($urandom_range(0, 1) != 0) ? 16'sd0 : -16'sd1;
      2, 3, 4: return WAIT_W'(int'($urandom_range(0, 6)) - 3);
      default: return WAIT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver: pick a stall level and a run length, hold it, repeat. The
  // long hold-off is counted here so the sender keeps offering meanwhile.
  initial begin
    int unsigned span;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        span        = HOLD_CYCLES;
        out_stall_i = 1'b1;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        span        = $urandom_range(1, 18);
        out_stall_i = 1'b1;
      end else begin
        span        = $urandom_range(1, 30);
        out_stall_i = 1'b0;
      end
      repeat (span) @(negedge clk_i);
    end
  end

  initial begin
    int unsigned remaining;
    int unsigned seg_len;
    int unsigned insert_pct;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = FUNC_INSERT;
    proc_id_i   = '0;
    wait_time_i = '0;
    gaps_on     = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: remove from an empty queue, fill to the brim with extreme
    // and tied waits, insert once more into the full queue, then take a few
    // out so that rotation and ties are exercised.
    offer(FUNC_REMOVE, 10'd999, 16'sh7FFF);
    for (int i = 0; i < 16; i++)
      offer(FUNC_INSERT, (i == 1) ? 10'd999 : ID_W'(i * 61), FILL_WAITS[i]);
    offer(FUNC_INSERT, 10'd512, 16'sh7FFF);
    repeat (5) offer(FUNC_REMOVE, 10'd0, 16'sd0);

    // Random: segments that lean toward filling, draining or a balance, so
    // the queue keeps crossing both full and empty. Back up the output once
    // early and once halfway to make the block stall its input.
    hold_req  = 1'b1;
    remaining = RANDOM_ITEMS;
    while (remaining > 0) begin
      seg_len    = $urandom_range(40, 120);
      insert_pct = ($urandom_range(0, 2) == 0) ? 50 : ($urandom_range(0, 1) ? 80 : 25);
      gaps_on    = ($urandom_range(0, 3) != 0);
      for (int j = 0; j < seg_len && remaining > 0; j++) begin
        if (remaining == RANDOM_ITEMS / 2)
          hold_req = 1'b1;
        calm = (remaining <= CALM_ITEMS);
        if ($urandom_range(1, 100) <= insert_pct)
          offer(FUNC_INSERT, ID_W'($urandom_range(0, 999)), pick_wait());
        else
          offer(FUNC_REMOVE, ID_W'($urandom_range(0, 999)), pick_wait());
        remaining--;
      end
    end
    in_valid_i = 1'b0;

    // Drain: wait out every outstanding result, then watch for strays.
    while (owed != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> fifo_remove_longest_wait.f
+incdir+hw/rtl
hw/rtl/frlw_pkg.sv
hw/rtl/frlw_ctrl.sv
hw/rtl/frlw_dp.sv
hw/rtl/fifo_remove_longest_wait.sv
hw/rtl/frlw_checker.sv
tb/sv/frlw_tb_pkg.sv
tb/sv/frlw_queue_checker.sv
tb/sv/tb_fifo_remove_longest_wait.sv
